// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the compensation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante implies cons");
// Next-cycle implication, checked at every rising edge out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante implies cons next cycle");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/otc_pkg.sv =====
// Package of the temperature compensation block: widths, constants, table, types.
package otc_pkg;

    localparam int TABLE_DEPTH_DEF = 100;
    localparam int ROM_ENTRIES     = 100;
    localparam int E4_SCALE        = 10000;

    localparam int RAW_W   = 16;
    localparam int TEMP_W  = 22;
    localparam int CORR_W  = 9;
    localparam int DIFF_W  = 10;
    localparam int FRAC_W  = 14;
    localparam int ADDR_W  = 8;
    localparam int QUOT_W  = 10;
    localparam int MUL_W   = 25;
    localparam int PROD_W  = 2 * MUL_W;

    // Reciprocal of 10000 scaled by 2^37; exact for dividends below 2^23.
    localparam int               RECIP_SH = 37;
    localparam logic [23:0]      RECIP_M  = 24'd13743896;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'd1;

    localparam logic signed [CORR_W-1:0] CORR_ROM [ROM_ENTRIES] = '{
        -9'sd165, -9'sd162, -9'sd160, -9'sd157, -9'sd155,
        -9'sd152, -9'sd150, -9'sd148, -9'sd144, -9'sd142,
        -9'sd136, -9'sd132, -9'sd130, -9'sd129, -9'sd126,
        -9'sd121, -9'sd116, -9'sd112, -9'sd108, -9'sd103,
        -9'sd99,  -9'sd95,  -9'sd90,  -9'sd86,  -9'sd81,
        -9'sd75,  -9'sd70,  -9'sd66,  -9'sd61,  -9'sd57,
        -9'sd53,  -9'sd46,  -9'sd42,  -9'sd38,  -9'sd32,
        -9'sd28,  -9'sd25,  -9'sd20,  -9'sd17,  -9'sd13,
        -9'sd9,   -9'sd5,   -9'sd2,   9'sd1,    9'sd4,
        9'sd7,    9'sd10,   9'sd12,   9'sd15,   9'sd16,
        9'sd18,   9'sd20,   9'sd21,   9'sd22,   9'sd23,
        9'sd23,   9'sd24,   9'sd23,   9'sd23,   9'sd22,
        9'sd21,   9'sd20,   9'sd18,   9'sd16,   9'sd14,
        9'sd11,   9'sd7,    9'sd3,    -9'sd1,   -9'sd5,
        -9'sd11,  -9'sd17,  -9'sd24,  -9'sd31,  -9'sd38,
        -9'sd45,  -9'sd52,  -9'sd58,  -9'sd67,  -9'sd71,
        -9'sd77,  -9'sd83,  -9'sd89,  -9'sd95,  -9'sd102,
        -9'sd108, -9'sd115, -9'sd121, -9'sd127, -9'sd134,
        -9'sd141, -9'sd147, -9'sd153, -9'sd159, -9'sd166,
        -9'sd177, -9'sd184, -9'sd190, -9'sd197, -9'sd203
    };

    // Table read; addresses past the stored entries return the last entry.
    function automatic logic signed [CORR_W-1:0] rom_read(input logic [ADDR_W-1:0] addr);
        logic [6:0] a;
        a = (addr >= ADDR_W'(ROM_ENTRIES)) ? 7'(ROM_ENTRIES - 1) : addr[6:0];
        return CORR_ROM[a];
    endfunction

    // Operand pair for the shared multiplier.
    typedef struct packed {
        logic                    en;
        logic signed [MUL_W-1:0] a;
        logic signed [MUL_W-1:0] b;
    } t_mul_req;

endpackage

// ===== rtl/core/otc_if.sv =====
// Handshake channel interfaces: reading in, result out, register write.
interface otc_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [otc_pkg::RAW_W-1:0]  raw_reading;
    logic                              read_ok;

    modport source (output valid, output raw_reading, output read_ok, input ready);
    modport sink   (input valid, input raw_reading, input read_ok, output ready);
endinterface

interface otc_out_if;
    logic                              valid;
    logic                              ready;
    logic                              measured;
    logic signed [otc_pkg::TEMP_W-1:0] temperature_e4;
    logic signed [otc_pkg::CORR_W-1:0] correction;
    logic                              correction_changed;

    modport source (output valid, output measured, output temperature_e4,
                    output correction, output correction_changed, input ready);
    modport sink   (input valid, input measured, input temperature_e4,
                    input correction, input correction_changed, output ready);
endinterface

interface otc_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [otc_pkg::CFG_IDX_W-1:0]        index;
    logic [otc_pkg::CFG_DAT_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/oscillator_temp_compensation.sv =====
// Top level of the oscillator temperature compensation block.
// Sequence: a reading with correction passes S_IDLE, S_TQ, S_MD, S_MQ, S_FIN; with the
// correction held (mode off) S_IDLE, S_TQ, S_FIN; when ignored S_IDLE, S_FIN. One shared
// multiplier sets this: scale, interpolate, divide by 10000 each take one pass through it.
// A new reading is accepted only back in S_IDLE, and S_FIN waits for a free output slot.
// Reset (synchronous, active low) clears the held temperature and correction and both registers.
`include "assert_macros.svh"

module oscillator_temp_compensation #(
    parameter int TABLE_DEPTH = otc_pkg::TABLE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    otc_in_if.sink          i_in,
    otc_out_if.source       o_out,
    otc_cfg_if.sink         i_cfg
);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // wait for a reading; scale it in the multiplier
    localparam logic [2:0] S_TQ   = 3'd1;  // form t, index, fraction, table entries
    localparam logic [2:0] S_MD   = 3'd2;  // multiply difference by fraction
    localparam logic [2:0] S_MQ   = 3'd3;  // multiply magnitude by reciprocal of 10000
    localparam logic [2:0] S_FIN  = 3'd4;  // finish and load the output word

    localparam logic [otc_pkg::ADDR_W-1:0] IDX_MAX = otc_pkg::ADDR_W'(TABLE_DEPTH - 2);
    localparam logic [otc_pkg::FRAC_W-1:0] FRAC_END = otc_pkg::FRAC_W'(otc_pkg::E4_SCALE);

    // Configuration
    logic r_en;
    logic r_mode;

    // Held state
    logic signed [otc_pkg::CORR_W-1:0] r_last_corr;
    logic signed [otc_pkg::TEMP_W-1:0] r_last_temp;

    // Work registers
    logic [2:0]                        r_state;
    logic signed [otc_pkg::RAW_W-1:0]  r_raw;
    logic                              r_meas;
    logic                              r_do_corr;
    logic signed [otc_pkg::TEMP_W-1:0] r_temp;
    logic signed [otc_pkg::CORR_W-1:0] r_base;
    logic signed [otc_pkg::DIFF_W-1:0] r_diff;
    logic [otc_pkg::FRAC_W-1:0]        r_frac;
    logic                              r_neg;

    // Output word
    logic                              r_out_valid;
    logic                              r_out_meas;
    logic signed [otc_pkg::TEMP_W-1:0] r_out_temp;
    logic signed [otc_pkg::CORR_W-1:0] r_out_corr;
    logic                              r_out_chg;

    // Shared multiplier
    otc_pkg::t_mul_req                 w_req;
    logic signed [otc_pkg::PROD_W-1:0] w_prod;

    otc_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_req),
        .o_prod (w_prod)
    );

    logic w_accept;
    logic w_meas_in;
    logic w_out_free;
    logic w_load;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_meas_in  = r_en && i_in.read_ok;
    assign w_out_free = !r_out_valid || o_out.ready;
    // Load the output word from the finish state once the slot frees up
    assign w_load     = (r_state == S_FIN) && w_out_free;

    // t = raw * 10000 / 256, truncated toward zero: bias negatives by 255 before the shift
    logic signed [29:0]                w_p30;
    logic signed [29:0]                w_biased;
    logic signed [otc_pkg::TEMP_W-1:0] w_t;
    logic [21:0]                       w_frac_full;
    logic [otc_pkg::ADDR_W-1:0]        w_idx_raw;
    logic [otc_pkg::ADDR_W-1:0]        w_idx;
    logic [otc_pkg::FRAC_W-1:0]        w_frac;
    logic signed [otc_pkg::CORR_W-1:0] w_base;
    logic signed [otc_pkg::CORR_W-1:0] w_next;

    assign w_p30       = w_prod[29:0];
    assign w_biased    = w_p30 + {22'd0, {8{w_p30[29]}}};
    assign w_t         = w_biased[29:8];
    // Fraction of a degree in 1/10000 units comes from the low byte alone
    assign w_frac_full = 22'(r_raw[7:0]) * 22'(otc_pkg::E4_SCALE);
    assign w_idx_raw   = {1'b0, r_raw[14:8]};

    always_comb begin
        if (r_raw[otc_pkg::RAW_W-1]) begin
            // Below zero: pin to the first entry
            w_idx  = '0;
            w_frac = '0;
        end else if (w_idx_raw > IDX_MAX) begin
            // Past the end: pin to the last interval start
            w_idx  = IDX_MAX;
            w_frac = '0;
        end else begin
            w_idx  = w_idx_raw;
            w_frac = w_frac_full[21:8];
        end
    end

    assign w_base = otc_pkg::rom_read(w_idx);
    assign w_next = otc_pkg::rom_read(w_idx + 1'b1);

    // Magnitude of diff * frac for the reciprocal pass
    logic signed [23:0] w_pd;
    logic [23:0]        w_mag;

    assign w_pd  = w_prod[23:0];
    assign w_mag = w_pd[23] ? 24'(-w_pd) : 24'(w_pd);

    // Interpolated correction
    logic [otc_pkg::QUOT_W-1:0] w_quot;
    logic signed [10:0]         w_step;
    logic signed [10:0]         w_comp11;
    logic signed [otc_pkg::CORR_W-1:0] w_comp;
    logic                       w_changed;

    assign w_quot    = w_prod[otc_pkg::RECIP_SH + otc_pkg::QUOT_W - 1:otc_pkg::RECIP_SH];
    assign w_step    = r_neg ? -$signed({1'b0, w_quot}) : $signed({1'b0, w_quot});
    assign w_comp11  = {{2{r_base[otc_pkg::CORR_W-1]}}, r_base} + w_step;
    assign w_comp    = w_comp11[otc_pkg::CORR_W-1:0];
    assign w_changed = r_do_corr && (w_comp != r_last_corr);

    // Multiplier operand selection
    always_comb begin
        w_req.en = 1'b0;
        w_req.a  = '0;
        w_req.b  = '0;
        case (r_state)
            S_IDLE: begin
                w_req.en = w_accept;
                w_req.a  = otc_pkg::MUL_W'(i_in.raw_reading);
                w_req.b  = otc_pkg::MUL_W'(otc_pkg::E4_SCALE);
            end
            S_MD: begin
                w_req.en = 1'b1;
                w_req.a  = otc_pkg::MUL_W'(r_diff);
                w_req.b  = $signed({{(otc_pkg::MUL_W - otc_pkg::FRAC_W){1'b0}}, r_frac});
            end
            S_MQ: begin
                w_req.en = 1'b1;
                w_req.a  = $signed({1'b0, w_mag});
                w_req.b  = $signed({1'b0, otc_pkg::RECIP_M});
            end
            default: begin
                w_req.en = 1'b0;
            end
        endcase
    end

    // Registers writable only while idle; hold off a write while a reading is in work
    assign i_cfg.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en   <= 1'b0;
            r_mode <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                otc_pkg::CFG_ENABLE: r_en   <= i_cfg.data[0];
                otc_pkg::CFG_MODE:   r_mode <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_corr <= '0;
            r_last_temp <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_raw     <= i_in.raw_reading;
                        r_meas    <= w_meas_in;
                        r_do_corr <= w_meas_in && r_mode;
                        // Ignored readings skip straight to the output
                        r_state   <= w_meas_in ? S_TQ : S_FIN;
                    end
                end
                S_TQ: begin
                    r_temp  <= w_t;
                    r_base  <= w_base;
                    r_diff  <= {w_next[otc_pkg::CORR_W-1], w_next}
                             - {w_base[otc_pkg::CORR_W-1], w_base};
                    r_frac  <= w_frac;
                    r_state <= r_do_corr ? S_MD : S_FIN;
                end
                S_MD: begin
                    r_state <= S_MQ;
                end
                S_MQ: begin
                    r_neg   <= w_prod[otc_pkg::PROD_W-1];
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // Hold here until the output slot frees up
                    if (w_out_free) begin
                        r_out_meas  <= r_meas;
                        r_out_chg   <= w_changed;
                        r_out_temp  <= r_meas ? r_temp : r_last_temp;
                        r_out_corr  <= w_changed ? w_comp : r_last_corr;
                        if (r_meas) begin
                            r_last_temp <= r_temp;
                        end
                        if (w_changed) begin
                            r_last_corr <= w_comp;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready               = (r_state == S_IDLE);
    assign o_out.valid              = r_out_valid;
    assign o_out.measured           = r_out_meas;
    assign o_out.temperature_e4     = r_out_temp;
    assign o_out.correction         = r_out_corr;
    assign o_out.correction_changed = r_out_chg;

    // Checks
    `ASSERT_IMPLIES(a_chg_needs_meas, i_clk, i_rst_n, r_out_valid && r_out_chg, r_out_meas)
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    `ASSERT_IMPLIES(a_frac_in_range, i_clk, i_rst_n, r_state == S_MD, r_frac < FRAC_END)

endmodule

// ===== rtl/core/otc_mul.sv =====
// Shared signed multiplier with registered product.
module otc_mul (
    input  logic                                  i_clk,
    input  otc_pkg::t_mul_req                     i_req,
    output logic signed [otc_pkg::PROD_W-1:0]     o_prod
);

    logic signed [otc_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= i_req.a * i_req.b;
        end
    end

    assign o_prod = r_prod;

endmodule
